/* rtl/core/auto_range_histogram_defines.svh */
// assertion macros for the auto-ranging histogram
`ifndef AUTO_RANGE_HISTOGRAM_DEFINES_SVH
`define AUTO_RANGE_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
`define ARH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("histogram assertion failed");
`define ARH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("histogram assertion failed");
`else
`define ARH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ARH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/arh_pkg.sv */
// shared types and constants of the auto-ranging histogram
`timescale 1ns / 1ps
package arh_pkg;
  localparam int SAMPLE_W    = 24;
  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_AW   = $clog2(MAX_SAMPLES);
  localparam int HELD_W      = $clog2(MAX_SAMPLES + 1);
  localparam int MAX_BINS    = 64;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int NBINS_W     = $clog2(MAX_BINS + 1);
  localparam int FRAC_BITS   = 8;
  localparam int BPU_W       = 10;
  localparam logic [BPU_W-1:0] BPU_RESET = 10'd32;
  localparam int COUNT_W     = 11;
  localparam int FRACT_W     = 17;
  localparam int Q16_SHIFT   = 16;
  localparam int RANGE_W     = SAMPLE_W + 1;
  localparam int DIVD_W      = 32;
  localparam int DIVS_W      = 26;
  localparam int OUT_DATA_W  = 64;
  localparam int OUT_USER_W  = 3;

  typedef enum logic [3:0] {
    S_IDLE, S_RANGE, S_NBINS, S_CHK, S_SRD, S_SMUL, S_SDIV, S_CRD, S_CWR,
    S_CMUL, S_CDIV, S_FRD, S_FMUL, S_FDIV, S_OUT
  } arh_state_t;

  typedef struct packed {
    logic load;
    logic calc_range;
    logic calc_nbins;
    logic st_rd;
    logic bin_mul;
    logic cnt_rd_bin;
    logic cnt_wr;
    logic ctr_mul;
    logic ctr_take;
    logic cnt_rd_idx;
    logic frac_mul;
    logic out_load;
    logic out_empty;
    logic next_bin;
    logic clear;
  } arh_cmd_t;

  typedef struct packed {
    logic zero_bins;
    logic div_done;
    logic samp_last;
    logic out_last;
  } arh_stat_t;
endpackage

/* rtl/core/auto_range_histogram.sv */
// top level of the auto-ranging histogram
`timescale 1ns / 1ps
`include "auto_range_histogram_defines.svh"
// Samples of a set (signed Q15.8) load at one per cycle into a 1024-entry
// store while the running minimum and maximum are tracked; further samples
// are dropped and flagged. The transaction with tlast set closes the set:
// the range is widened to whole units, the bin count derived from the
// resolution register (capped at 64), and each stored sample is binned
// through a shared 32-step serial divider.
// Each bin result then takes two divider runs plus the output handshake.
// A set that yields no bins gives a single transaction with status set.
// No sample is accepted until the last result of the set has been taken.
// The user must write configuration only while the block is idle; it is not enforced.
module auto_range_histogram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,   // bins_per_unit_sixteenths
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // sample_value
  input  logic        in_tlast,      // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,     // bin_index, bin_center, bin_count, bin_fraction
  output logic [2:0]  out_tuser,     // status, bins_truncated, samples_dropped
  output logic        out_tlast      // last_result
);
  import arh_pkg::*;

  arh_cmd_t  cmd;
  arh_stat_t stat;

  // sequencer
  arh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  arh_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_sample  (in_tdata),
    .out_data   (out_tdata),
    .out_user   (out_tuser),
    .out_last   (out_tlast)
  );

  // input and output never open together
  `ARH_ASSERT_IMP(a_no_overlap, clk, rst_n, in_tready, !out_tvalid)
  // the final result of a set returns the block to loading
  `ARH_ASSERT_NXT(a_back_to_load, clk, rst_n, out_tvalid && out_tready && out_tlast, in_tready)
  // a no-bins status is always the single, final result
  `ARH_ASSERT_IMP(a_status_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast)
endmodule

/* rtl/core/arh_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module arh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

/* rtl/core/arh_div.sv */
// radix-2 restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module arh_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [arh_pkg::DIVD_W-1:0] dividend,
  input  logic [arh_pkg::DIVS_W-1:0] divisor,
  output logic [arh_pkg::DIVD_W-1:0] quotient,
  output logic                       done
);
  import arh_pkg::*;
  localparam int CNT_W = $clog2(DIVD_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(DIVD_W);

  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVS_W+1:0] trial;

  // one shift-subtract step
  always_comb begin
    trial = {1'b0, rem_r, quo_r[DIVD_W-1]} - {2'b00, dvs_r};
    if (!trial[DIVS_W+1]) begin
      rem_nxt = trial[DIVS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[DIVS_W-2:0], quo_r[DIVD_W-1]};
      quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
    end
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;
endmodule

/* rtl/core/arh_datapath.sv */
// histogram datapath: sample store, range, binning, counts and result fields
`timescale 1ns / 1ps
module arh_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  arh_pkg::arh_cmd_t              cmd,
  output arh_pkg::arh_stat_t             stat,
  input  logic                           cfg_wr_en,
  input  logic [arh_pkg::BPU_W-1:0]      cfg_wr_data,
  input  logic [arh_pkg::SAMPLE_W-1:0]   in_sample,
  output logic [arh_pkg::OUT_DATA_W-1:0] out_data,
  output logic [arh_pkg::OUT_USER_W-1:0] out_user,
  output logic                           out_last
);
  import arh_pkg::*;
  localparam int NB_W = RANGE_W - FRAC_BITS + BPU_W - 4;

  logic [BPU_W-1:0]           bpu_r;
  logic signed [SAMPLE_W-1:0] min_r, max_r;
  logic [HELD_W-1:0]          held_r;
  logic                       ovf_r;
  logic signed [SAMPLE_W-1:0] lo_r;
  logic [RANGE_W-1:0]         range_r;
  logic [NBINS_W-1:0]         nbins_r;
  logic                       trunc_r;
  logic                       zero_r;
  logic [HELD_W-1:0]          j_r;
  logic [BIN_W-1:0]           i_r;
  logic [MAX_BINS-1:0]        vld_r;
  logic [DIVD_W-1:0]          dvd_r;
  logic [DIVS_W-1:0]          dvs_r;
  logic                       div_go_r;
  logic signed [SAMPLE_W-1:0] center_r;
  logic [COUNT_W-1:0]         cnt_r;
  logic [BIN_W-1:0]           o_idx_r;
  logic [SAMPLE_W-1:0]        o_ctr_r;
  logic [COUNT_W-1:0]         o_cnt_r;
  logic [FRACT_W-1:0]         o_frac_r;
  logic                       o_stat_r, o_trunc_r, o_ovf_r, o_last_r;

  logic signed [SAMPLE_W-1:0] smp;
  logic                       st_we;
  logic [SAMPLE_W-1:0]        st_rdata;
  logic [DIVD_W-1:0]          quo;
  logic                       div_done;
  logic [BIN_W-1:0]           bin;
  logic [COUNT_W-1:0]         cr_rdata;
  logic [COUNT_W-1:0]         cnt_base;
  logic [BIN_W-1:0]           cr_raddr;
  logic signed [RANGE_W:0]    hi;
  logic signed [RANGE_W:0]    rng_full;
  logic [RANGE_W-FRAC_BITS-1:0] units;
  logic [RANGE_W-FRAC_BITS+BPU_W-1:0] prod;
  logic [RANGE_W-FRAC_BITS+BPU_W-5:0] nb;
  logic [RANGE_W-1:0]         diff;
  logic signed [RANGE_W+1:0]  ctr_sum;

  assign smp   = $signed(in_sample);
  assign st_we = cmd.load && (held_r < HELD_W'(MAX_SAMPLES));

  // sample store
  arh_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(held_r[SAMPLE_AW-1:0]),
    .wdata(in_sample),
    .raddr(j_r[SAMPLE_AW-1:0]),
    .rdata(st_rdata)
  );

  // bin of the current sample, clamped to the last bin
  assign bin = (quo >= DIVD_W'(nbins_r)) ? BIN_W'(nbins_r - 1'b1) : quo[BIN_W-1:0];

  // bin count store, entries without a valid bit read as zero
  assign cr_raddr = cmd.cnt_rd_idx ? i_r : bin;
  arh_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_BINS)) u_counts (
    .clk  (clk),
    .we   (cmd.cnt_wr),
    .waddr(bin),
    .wdata(cnt_base + 1'b1),
    .raddr(cr_raddr),
    .rdata(cr_rdata)
  );
  assign cnt_base = vld_r[cr_raddr] ? cr_rdata : '0;

  // shared divider
  arh_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_go_r),
    .dividend(dvd_r),
    .divisor (dvs_r),
    .quotient(quo),
    .done    (div_done)
  );

  // range and bin count arithmetic
  always_comb begin
    if (max_r[FRAC_BITS-1:0] == '0) begin
      hi = (RANGE_W+1)'(max_r);
    end else begin
      hi = (RANGE_W+1)'($signed({max_r[SAMPLE_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}}))
           + (RANGE_W+1)'(1 << FRAC_BITS);
    end
    rng_full = hi - (RANGE_W+1)'(min_r & ~SAMPLE_W'((1 << FRAC_BITS) - 1));
    units    = range_r[RANGE_W-1:FRAC_BITS];
    prod     = units * bpu_r;
    nb       = prod[RANGE_W-FRAC_BITS+BPU_W-1:4];
    diff     = RANGE_W'((RANGE_W+1)'($signed(st_rdata)) - (RANGE_W+1)'(lo_r));
    ctr_sum  = (RANGE_W+2)'(lo_r) + $signed({2'b00, quo[RANGE_W-1:0]});
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpu_r <= BPU_RESET;
    end else if (cfg_wr_en) begin
      bpu_r <= cfg_wr_data;
    end
  end

  // set state: running extremes, fill count, drop flag, count valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      min_r  <= '0;
      max_r  <= '0;
      held_r <= '0;
      ovf_r  <= 1'b0;
      vld_r  <= '0;
    end else begin
      if (cmd.load) begin
        if (!st_we) begin
          ovf_r <= 1'b1;
        end else begin
          held_r <= held_r + 1'b1;
          if (held_r == '0 || smp < min_r) min_r <= smp;
          if (held_r == '0 || smp > max_r) max_r <= smp;
        end
      end
      if (cmd.cnt_wr) begin
        vld_r[bin] <= 1'b1;
      end
    end
  end

  // per-set working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_go_r <= 1'b0;
      j_r      <= '0;
      i_r      <= '0;
    end else begin
      div_go_r <= cmd.bin_mul || cmd.ctr_mul || cmd.frac_mul;
      if (cmd.calc_nbins) begin
        j_r <= '0;
        i_r <= '0;
      end
      if (cmd.cnt_wr)   j_r <= j_r + 1'b1;
      if (cmd.next_bin) i_r <= i_r + 1'b1;
    end
  end

  // range, bin count and operand registers
  always_ff @(posedge clk) begin
    if (cmd.calc_range) begin
      lo_r    <= min_r & ~SAMPLE_W'((1 << FRAC_BITS) - 1);
      range_r <= rng_full[RANGE_W-1:0];
    end
    if (cmd.calc_nbins) begin
      trunc_r <= nb > NB_W'(MAX_BINS);
      nbins_r <= (nb > NB_W'(MAX_BINS)) ? NBINS_W'(MAX_BINS) : nb[NBINS_W-1:0];
      zero_r  <= (nb == '0) || (range_r == '0) || (held_r == '0);
    end
    if (cmd.bin_mul) begin
      dvd_r <= DIVD_W'(diff) * DIVD_W'(nbins_r);
      dvs_r <= DIVS_W'(range_r);
    end
    if (cmd.ctr_mul) begin
      dvd_r <= DIVD_W'({i_r, 1'b1}) * DIVD_W'(range_r) + DIVD_W'(nbins_r);
      dvs_r <= DIVS_W'({nbins_r, 1'b0});
    end
    if (cmd.frac_mul) begin
      cnt_r <= cnt_base;
      dvd_r <= DIVD_W'({cnt_base, {Q16_SHIFT{1'b0}}}) + DIVD_W'(held_r >> 1);
      dvs_r <= DIVS_W'(held_r);
    end
    if (cmd.ctr_take) begin
      center_r <= (ctr_sum > (RANGE_W+2)'((1 << (SAMPLE_W - 1)) - 1)) ?
                  SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1) : ctr_sum[SAMPLE_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_idx_r   <= i_r;
      o_ctr_r   <= center_r;
      o_cnt_r   <= cnt_r;
      o_frac_r  <= quo[FRACT_W-1:0];
      o_stat_r  <= 1'b0;
      o_trunc_r <= trunc_r;
      o_ovf_r   <= ovf_r;
      o_last_r  <= (NBINS_W'(i_r) == nbins_r - 1'b1);
    end else if (cmd.out_empty) begin
      o_idx_r   <= '0;
      o_ctr_r   <= '0;
      o_cnt_r   <= '0;
      o_frac_r  <= '0;
      o_stat_r  <= 1'b1;
      o_trunc_r <= trunc_r;
      o_ovf_r   <= ovf_r;
      o_last_r  <= 1'b1;
    end
  end

  assign out_data = {6'b0, o_frac_r, o_cnt_r, o_ctr_r, o_idx_r};
  assign out_user = {o_ovf_r, o_trunc_r, o_stat_r};
  assign out_last = o_last_r;

  assign stat.zero_bins = zero_r;
  assign stat.div_done  = div_done;
  assign stat.samp_last = (j_r == held_r - 1'b1);
  assign stat.out_last  = o_last_r;
endmodule

/* rtl/core/arh_ctrl.sv */
// histogram controller: sequences load, binning pass and result output
`timescale 1ns / 1ps
module arh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tlast,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  arh_pkg::arh_stat_t stat,
  output arh_pkg::arh_cmd_t  cmd
);
  import arh_pkg::*;

  arh_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd.calc_range = 1'b1;
        state_nxt      = S_NBINS;
      end
      S_NBINS: begin
        cmd.calc_nbins = 1'b1;
        state_nxt      = S_CHK;
      end
      S_CHK: begin
        if (stat.zero_bins) begin
          cmd.out_empty = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cmd.st_rd = 1'b1;
        state_nxt = S_SMUL;
      end
      S_SMUL: begin
        cmd.bin_mul = 1'b1;
        state_nxt   = S_SDIV;
      end
      S_SDIV: begin
        if (stat.div_done) state_nxt = S_CRD;
      end
      S_CRD: begin
        cmd.cnt_rd_bin = 1'b1;
        state_nxt      = S_CWR;
      end
      S_CWR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = stat.samp_last ? S_CMUL : S_SRD;
      end
      S_CMUL: begin
        cmd.ctr_mul = 1'b1;
        state_nxt   = S_CDIV;
      end
      S_CDIV: begin
        if (stat.div_done) begin
          cmd.ctr_take = 1'b1;
          state_nxt    = S_FRD;
        end
      end
      S_FRD: begin
        cmd.cnt_rd_idx = 1'b1;
        state_nxt      = S_FMUL;
      end
      S_FMUL: begin
        cmd.cnt_rd_idx = 1'b1;
        cmd.frac_mul   = 1'b1;
        state_nxt      = S_FDIV;
      end
      S_FDIV: begin
        if (stat.div_done) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (stat.out_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.next_bin = 1'b1;
            state_nxt    = S_CMUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

/* verif/tb_auto_range_histogram.sv */
// self-checking testbench of the auto-ranging histogram
`timescale 1ns / 1ps
module tb_auto_range_histogram;
  import arh_pkg::*;

  localparam int  HALF_PERIOD = 6;
  localparam int  RESET_CYCLES = 12;
  localparam int  IDLE_PCT = 37;
  localparam int  SETTLE_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int  NO_CFG = -1;
  localparam int  USE_PREDICTOR = 0;
  localparam int  TYPED_ZERO_BINS = 1;

  typedef struct packed {
    logic [BIN_W-1:0]    idx;
    logic [SAMPLE_W-1:0] center;
    logic [COUNT_W-1:0]  count;
    logic [FRACT_W-1:0]  frac;
    logic                status;
    logic                trunc;
    logic                dropped;
    logic                last;
  } bin_result_t;

  typedef struct {
    int          cfg;
    logic [23:0] sample;
    logic        last;
    int          kind;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [9:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // predictor state
  int          held_samples[$];
  longint      set_min, set_max;
  bit          set_overflow;
  int          bpu;
  bin_result_t expected_bins[$];

  int     mismatches = 0;
  longint cycles = 0;
  bit     no_idle = 1'b0;

  auto_range_histogram uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // accumulate one accepted sample, predict bins when the set closes
  task automatic histogram_take(input logic [23:0] raw, input logic last);
    longint v, lo, hi, range, nbins, b, held, center;
    bit trunc;
    int counts[MAX_BINS];
    bin_result_t r;
    v = longint'(signed'(raw));
    if (held_samples.size() < MAX_SAMPLES) begin
      if (held_samples.size() == 0) begin
        set_min = v;
        set_max = v;
      end else begin
        if (v < set_min) set_min = v;
        if (v > set_max) set_max = v;
      end
      held_samples.insert(held_samples.size(), int'(v));
    end else begin
      set_overflow = 1'b1;
    end
    if (!last) return;
    // widen outward to whole units
    lo = set_min - (set_min & 255);
    hi = set_max + ((256 - (set_max & 255)) & 255);
    range = hi - lo;
    nbins = ((range / 256) * bpu) / 16;
    trunc = nbins > MAX_BINS;
    if (trunc) nbins = MAX_BINS;
    held = held_samples.size();
    if (nbins <= 0 || range <= 0 || held == 0) begin
      r = '0;
      r.status = 1'b1;
      r.trunc = trunc;
      r.dropped = set_overflow;
      r.last = 1'b1;
      expected_bins.insert(expected_bins.size(), r);
    end else begin
      foreach (counts[k]) counts[k] = 0;
      foreach (held_samples[k]) begin
        b = ((longint'(held_samples[k]) - lo) * nbins) / range;
        if (b >= nbins) b = nbins - 1;
        counts[b]++;
      end
      for (int i = 0; i < nbins; i++) begin
        center = lo + ((2 * i + 1) * range + nbins) / (2 * nbins);
        if (center > 8388607) center = 8388607;
        r.idx = i[BIN_W-1:0];
        r.center = center[SAMPLE_W-1:0];
        r.count = counts[i][COUNT_W-1:0];
        r.frac = FRACT_W'((longint'(counts[i]) * 65536 + held / 2) / held);
        r.status = 1'b0;
        r.trunc = trunc;
        r.dropped = set_overflow;
        r.last = (i + 1 == nbins);
        expected_bins.insert(expected_bins.size(), r);
      end
    end
    held_samples.delete();
    set_min = 0;
    set_max = 0;
    set_overflow = 1'b0;
  endtask

  // offer one sample with random idle cycles, wait for the transaction
  task automatic send_sample(input logic [23:0] sample, input logic last);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sample;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    histogram_take(sample, last);
  endtask

  // resolution write once all bins of the last set are out
  task automatic write_bpu(input logic [9:0] value);
    in_tvalid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bpu = value;
  endtask

  // receiver: random backpressure and result compare
  always @(posedge clk) begin
    bin_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.idx = out_tdata[5:0];
      got.center = out_tdata[29:6];
      got.count = out_tdata[40:30];
      got.frac = out_tdata[57:41];
      got.status = out_tuser[0];
      got.trunc = out_tuser[1];
      got.dropped = out_tuser[2];
      got.last = out_tlast;
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idx %0d count %0d", got.idx, got.count);
      end else begin
        want = expected_bins.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp idx %0d ctr %0d cnt %0d frac %0d st %b tr %b dr %b ",
                      "last %b, got idx %0d ctr %0d cnt %0d frac %0d st %b tr %b dr %b last %b"},
              want.idx, $signed(want.center), want.count, want.frac, want.status,
              want.trunc, want.dropped, want.last,
              got.idx, $signed(got.center), got.count, got.frac, got.status,
              got.trunc, got.dropped, got.last);
        end
      end
    end
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // directed stimulus: extremes, zero-bin sets, sample at the maximum
  stim_row_t directed[] = '{
    '{NO_CFG, 24'd0, 1'b1, TYPED_ZERO_BINS},
    '{NO_CFG, 24'h800000, 1'b0, USE_PREDICTOR},
    '{NO_CFG, 24'h7FFFFF, 1'b1, USE_PREDICTOR},
    '{1, 24'd0, 1'b0, USE_PREDICTOR},
    '{NO_CFG, 24'd4096, 1'b1, USE_PREDICTOR},
    '{0, 24'd0, 1'b0, USE_PREDICTOR},
    '{NO_CFG, 24'd1000, 1'b1, TYPED_ZERO_BINS},
    '{1023, -24'sd300, 1'b0, USE_PREDICTOR},
    '{NO_CFG, 24'd300, 1'b1, USE_PREDICTOR},
    '{16, 24'd0, 1'b0, USE_PREDICTOR},
    '{NO_CFG, 24'd256, 1'b0, USE_PREDICTOR},
    '{NO_CFG, 24'd512, 1'b0, USE_PREDICTOR},
    '{NO_CFG, 24'd768, 1'b0, USE_PREDICTOR},
    '{NO_CFG, 24'd1024, 1'b1, USE_PREDICTOR},
    '{32, -24'sd1, 1'b0, USE_PREDICTOR},
    '{NO_CFG, -24'sd255, 1'b1, USE_PREDICTOR},
    '{NO_CFG, 24'd7, 1'b1, USE_PREDICTOR},
    '{1, 24'd100, 1'b1, TYPED_ZERO_BINS}
  };

  initial begin
    logic [23:0] base, s;
    int len, spread, mode;
    logic [9:0] bpu_pick;
    bin_result_t typed;
    bpu = BPU_RESET;
    set_min = 0;
    set_max = 0;
    set_overflow = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed[k]) begin
      if (directed[k].cfg != NO_CFG) write_bpu(directed[k].cfg[9:0]);
      if (directed[k].kind == TYPED_ZERO_BINS) begin
        send_sample(directed[k].sample, directed[k].last);
        // predictor output replaced by the typed zero-bin result
        void'(expected_bins.pop_back());
        typed = '{idx: '0, center: '0, count: '0, frac: '0,
          status: 1'b1, trunc: 1'b0, dropped: 1'b0, last: 1'b1};
        expected_bins.insert(expected_bins.size(), typed);
      end else begin
        send_sample(directed[k].sample, directed[k].last);
      end
    end

    // random sets, mostly narrow spreads, some full-scale
    for (int n = 0; n < 280; ) begin
      no_idle = (n >= 100 && n < 160);
      if ($urandom_range(3) == 0) begin
        mode = $urandom_range(4);
        bpu_pick = (mode == 0) ? 10'd1 : (mode == 1) ? 10'd1023 :
                   (mode == 2) ? 10'd16 : 10'($urandom_range(1023));
        write_bpu(bpu_pick);
      end
      len = $urandom_range(1, 8);
      base = 24'($urandom);
      spread = ($urandom_range(4) == 0) ? 0 : (1 << $urandom_range(2, 14));
      for (int j = 0; j < len; j++) begin
        s = (spread == 0) ? 24'($urandom) : base + 24'($urandom_range(spread));
        send_sample(s, j == len - 1);
        n++;
      end
    end
    in_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
